### rtl/jbt_pkg.sv
// Shared types, codes and literal tables of the JSON byte tokenizer.
package jbt_pkg;

  localparam logic [3:0] KindInt    = 4'd0;
  localparam logic [3:0] KindReal   = 4'd1;
  localparam logic [3:0] KindString = 4'd2;
  localparam logic [3:0] KindNull   = 4'd3;
  localparam logic [3:0] KindPunct  = 4'd6;
  localparam logic [3:0] KindError  = 4'd7;
  localparam logic [3:0] KindEnd    = 4'd8;

  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChLf     = 8'd10;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChQuote  = 8'd34;
  localparam logic [7:0] ChBslash = 8'd92;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       byte_valid;
    logic       done;
  } result_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MaxResults-1:0]     res;
  } bundle_t;

  function automatic result_t mk_result(logic [3:0] kind, logic [7:0] data,
                                        logic byte_valid, logic done);
    result_t r;
    r.kind       = kind;
    r.data       = data;
    r.byte_valid = byte_valid;
    r.done       = done;
    return r;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] which);
    logic [2:0] len;
    unique case (which)
      2'd0:    len = 3'd4;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] which, logic [2:0] pos);
    logic [7:0] c;
    c = 8'd0;
    unique case (which)
      2'd0: begin
        unique case (pos)
          3'd0:    c = "n";
          3'd1:    c = "u";
          3'd2:    c = "l";
          3'd3:    c = "l";
          default: c = 8'd0;
        endcase
      end
      2'd1: begin
        unique case (pos)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          3'd3:    c = "e";
          default: c = 8'd0;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          3'd4:    c = "e";
          default: c = 8'd0;
        endcase
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/jbt_front.sv
// Front end: accepts text bytes, runs the lexer state and forms result bundles.
module jbt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output jbt_pkg::bundle_t q_data_o
);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeNumber  = 3'd1;
  localparam logic [2:0] ModeString  = 3'd2;
  localparam logic [2:0] ModeEscape  = 3'd3;
  localparam logic [2:0] ModeLiteral = 3'd4;

  logic [2:0] mode_q, mode_d;
  logic       dot_q, dot_d;
  logic [1:0] which_q, which_d;
  logic [2:0] pos_q, pos_d;

  jbt_pkg::bundle_t bnd;
  logic [1:0]       n;
  logic             idle_go;
  logic             dot_next;
  logic [3:0]       num_kind;
  logic [2:0]       len;
  logic [2:0]       pos_inc;
  logic             lit_match;
  logic [1:0]       new_which;
  logic             accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    mode_d    = mode_q;
    dot_d     = dot_q;
    which_d   = which_q;
    pos_d     = pos_q;
    bnd       = '0;
    n         = 2'd0;
    idle_go   = 1'b0;
    num_kind  = dot_q ? jbt_pkg::KindReal : jbt_pkg::KindInt;
    dot_next  = dot_q | (in_byte_i == ".");
    len       = jbt_pkg::lit_len(which_q);
    pos_inc   = pos_q + 3'd1;
    lit_match = (pos_q < len) && (pos_q < 3'd5) &&
                (jbt_pkg::lit_char(which_q, pos_q) == in_byte_i);
    new_which = (in_byte_i == "n") ? 2'd0 : (in_byte_i == "t") ? 2'd1 : 2'd2;

    if (in_byte_i == 8'd0) begin
      unique case (mode_q)
        ModeNumber: begin
          bnd.res[n] = jbt_pkg::mk_result(num_kind, 8'd0, 1'b0, 1'b1);
          n = n + 2'd1;
        end
        ModeEscape: begin
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, jbt_pkg::ChBslash,
                                          1'b1, 1'b0);
          n = n + 2'd1;
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, 8'd0, 1'b0, 1'b1);
          n = n + 2'd1;
        end
        ModeString: begin
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, 8'd0, 1'b0, 1'b1);
          n = n + 2'd1;
        end
        ModeLiteral: begin
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindError, 8'd0, 1'b0, 1'b1);
          n = n + 2'd1;
        end
        default: ;
      endcase
      bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindEnd, 8'd0, 1'b0, 1'b0);
      n = n + 2'd1;
      mode_d  = ModeIdle;
      dot_d   = 1'b0;
      which_d = 2'd0;
      pos_d   = 3'd0;
    end else begin
      unique case (mode_q)
        ModeNumber: begin
          if ((in_byte_i >= "0" && in_byte_i <= "9") || in_byte_i == ".") begin
            dot_d = dot_next;
            bnd.res[n] = jbt_pkg::mk_result(dot_next ? jbt_pkg::KindReal
                                                     : jbt_pkg::KindInt,
                                            in_byte_i, 1'b1, 1'b0);
            n = n + 2'd1;
          end else begin
            bnd.res[n] = jbt_pkg::mk_result(num_kind, 8'd0, 1'b0, 1'b1);
            n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        ModeString: begin
          if (in_byte_i == jbt_pkg::ChQuote) begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, 8'd0, 1'b0, 1'b1);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end else if (in_byte_i == jbt_pkg::ChBslash) begin
            mode_d = ModeEscape;
          end else begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, in_byte_i,
                                            1'b1, 1'b0);
            n = n + 2'd1;
          end
        end
        ModeEscape: begin
          if (in_byte_i == jbt_pkg::ChQuote || in_byte_i == jbt_pkg::ChBslash) begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, in_byte_i,
                                            1'b1, 1'b0);
            n = n + 2'd1;
          end else if (in_byte_i == "r") begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, jbt_pkg::ChCr,
                                            1'b1, 1'b0);
            n = n + 2'd1;
          end else if (in_byte_i == "n") begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, jbt_pkg::ChLf,
                                            1'b1, 1'b0);
            n = n + 2'd1;
          end else begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, jbt_pkg::ChBslash,
                                            1'b1, 1'b0);
            n = n + 2'd1;
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindString, in_byte_i,
                                            1'b1, 1'b0);
            n = n + 2'd1;
          end
          mode_d = ModeString;
        end
        ModeLiteral: begin
          if (lit_match) begin
            pos_d = pos_inc;
            if (pos_inc >= len) begin
              bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindNull + {2'b00, which_q},
                                              in_byte_i, 1'b1, 1'b1);
              mode_d = ModeIdle;
            end else begin
              bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindNull + {2'b00, which_q},
                                              in_byte_i, 1'b1, 1'b0);
            end
            n = n + 2'd1;
          end else begin
            bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindError, in_byte_i,
                                            1'b1, 1'b1);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        default: idle_go = 1'b1;
      endcase

      if (idle_go) begin
        mode_d = ModeIdle;
        if (in_byte_i == jbt_pkg::ChSpace || in_byte_i == jbt_pkg::ChTab ||
            in_byte_i == jbt_pkg::ChCr || in_byte_i == jbt_pkg::ChLf) begin
          mode_d = ModeIdle;
        end else if (in_byte_i == "-" || (in_byte_i >= "0" && in_byte_i <= "9")) begin
          mode_d = ModeNumber;
          dot_d  = 1'b0;
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindInt, in_byte_i, 1'b1, 1'b0);
          n = n + 2'd1;
        end else if (in_byte_i == jbt_pkg::ChQuote) begin
          mode_d = ModeString;
        end else if (in_byte_i == "n" || in_byte_i == "t" || in_byte_i == "f") begin
          which_d = new_which;
          pos_d   = 3'd1;
          mode_d  = ModeLiteral;
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindNull + {2'b00, new_which},
                                          in_byte_i, 1'b1, 1'b0);
          n = n + 2'd1;
        end else if (in_byte_i == "[" || in_byte_i == "]" || in_byte_i == "{" ||
                     in_byte_i == "}" || in_byte_i == "," || in_byte_i == ":") begin
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindPunct, in_byte_i, 1'b1, 1'b1);
          n = n + 2'd1;
        end else begin
          bnd.res[n] = jbt_pkg::mk_result(jbt_pkg::KindError, in_byte_i, 1'b1, 1'b1);
          n = n + 2'd1;
        end
      end
    end
    bnd.cnt = n;
  end

  assign q_push_o = accept && (n != 2'd0);
  assign q_data_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      dot_q   <= 1'b0;
      which_q <= 2'd0;
      pos_q   <= 3'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      dot_q   <= dot_d;
      which_q <= which_d;
      pos_q   <= pos_d;
    end
  end

endmodule

### rtl/jbt_queue.sv
// Small first-in first-out queue of result bundles between front and back.
module jbt_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jbt_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output jbt_pkg::bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jbt_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/jbt_back.sv
// Back end: unpacks queued bundles into single results behind an output register.
module jbt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  jbt_pkg::bundle_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [3:0]       token_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             token_done_o,
  output logic             run_last_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  jbt_pkg::result_t res_q;
  logic             last_q;
  logic             load;
  logic             is_last;

  assign load    = !q_empty_i && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == (q_head_i.cnt - 2'd1));
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= q_head_i.res[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign token_kind_o = res_q.kind;
  assign out_byte_o   = res_q.data;
  assign byte_valid_o = res_q.byte_valid;
  assign token_done_o = res_q.done;
  assign run_last_o   = last_q;

endmodule

### rtl/json_byte_tokenizer.sv
// Top level of the streaming JSON byte tokenizer.
//
// Usage: the input channel takes one text byte per request on in_byte_i, with
// in_valid_i and in_stall_o; a zero byte marks the end of the text. The output
// channel gives one result per request on out_valid_o and out_stall_i, with
// token_kind_o, out_byte_o, byte_valid_o, token_done_o and run_last_o; run_last_o
// marks the last result caused by one input byte.
// Results of a byte enter the bundle queue, then the back end's output register.
// Throughput is one byte per cycle while each byte gives at most one result and
// the receiver does not stall; a byte with several results takes a slot for each,
// and bytes with no result (whitespace, an opening quote, a backslash) take none.
// Unless stalled, the output side sends one result per cycle from the queue, so
// the queue of QueueDepth bundles absorbs the bursts of two and three results.
// After reset the lexer is idle between tokens and the queue is empty.
// When the receiver stalls, the current result holds; once the queue fills,
// in_stall_o rises and no further bytes are taken.
module json_byte_tokenizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       token_done_o,
  output logic       run_last_o
);

  logic             q_push, q_full, q_pop, q_empty;
  jbt_pkg::bundle_t q_wdata, q_head;

  jbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  jbt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  jbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .token_done_o (token_done_o),
    .run_last_o   (run_last_o)
  );

endmodule
